>>> rtl/csy_pkg.sv
// Package for the correlator peak symbol sync block.
// Holds default sizes, template coefficients and the MAC sequencer state type.
// No dependencies.
package csy_pkg;

  localparam int TAPS_DEF     = 1070;
  localparam int SPS_DEF      = 5;
  localparam int SAMPLE_W_DEF = 16;

  localparam int THRESH_W = 27;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 27'd200;

  localparam int COEF_W      = 15;
  localparam int COEF_FRAC   = 14;
  localparam int SHAPE_LEN   = 5;
  localparam int SHAPE_IDX_W = 3;

  localparam logic signed [COEF_W-1:0] SHAPE_Q14 [SHAPE_LEN] = '{
    15'sd0, 15'sd9631, 15'sd15583, 15'sd15583, 15'sd9631
  };

  typedef enum logic [1:0] {
    MAC_IDLE,
    MAC_RUN,
    MAC_DRAIN
  } mac_state_t;

endpackage

>>> rtl/csy_if.sv
// Handshake channels for the correlator peak symbol sync block.
// Sample input, symbol output and threshold write channels; no dependencies.
interface csy_sample_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface csy_symbol_if;
  logic valid;
  logic ready;
  logic symbol_positive;

  modport source (output valid, output symbol_positive, input ready);
  modport sink   (input valid, input symbol_positive, output ready);
endinterface

interface csy_cfg_if;
  logic        valid;
  logic        ready;
  logic [26:0] peak_threshold;

  modport source (output valid, output peak_threshold, input ready);
  modport sink   (input valid, input peak_threshold, output ready);
endinterface

>>> rtl/csy_mac.sv
// Delay line memory and shared multiply-accumulate sequencer.
// Forms one template correlation per stored sample; uses csy_pkg.
module csy_mac
  import csy_pkg::*;
#(
  parameter int TAPS         = TAPS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_W_DEF,
  localparam int CORR_W      = SAMPLE_WIDTH + 1 + $clog2(TAPS)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic                           idle,
  output logic                           done,
  output logic signed [CORR_W-1:0]       corr
);

  localparam int ADDR_W = $clog2(TAPS);
  localparam int FILL_W = $clog2(TAPS + 1);
  localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
  localparam int ACC_W  = CORR_W + COEF_FRAC;

  mac_state_t state, state_next;

  logic signed [SAMPLE_WIDTH-1:0] mem [TAPS];
  logic signed [SAMPLE_WIDTH-1:0] rdata;

  logic [ADDR_W-1:0]      ring_pos;
  logic [ADDR_W-1:0]      ring_pos_inc;
  logic [FILL_W-1:0]      fill;
  logic [ADDR_W-1:0]      rd_addr;
  logic [ADDR_W-1:0]      tap_cnt;
  logic [SHAPE_IDX_W-1:0] shape_idx;
  logic                   neg;
  logic                   last_tap;

  logic                     v1;
  logic                     v2;
  logic                     zero1;
  logic signed [COEF_W-1:0] coef1;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  assign ring_pos_inc = (ring_pos == ADDR_W'(TAPS - 1)) ? '0 : ring_pos + 1'b1;
  assign last_tap     = (tap_cnt == ADDR_W'(TAPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MAC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state)
      MAC_IDLE: begin
        if (start) begin
          state_next = MAC_RUN;
        end
      end
      MAC_RUN: begin
        if (last_tap) begin
          state_next = MAC_DRAIN;
        end
      end
      MAC_DRAIN: begin
        if (!v1 && !v2) begin
          done       = 1'b1;
          state_next = MAC_IDLE;
        end
      end
      default: begin
        state_next = MAC_IDLE;
      end
    endcase
  end

  assign idle = (state == MAC_IDLE);
  assign corr = acc[ACC_W-1:COEF_FRAC];

  always_ff @(posedge clk) begin
    if (start) begin
      mem[ring_pos] <= sample;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_pos <= '0;
      fill     <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
    end else begin
      v1 <= (state == MAC_RUN);
      v2 <= v1;
      if (start) begin
        ring_pos <= ring_pos_inc;
        if (fill != FILL_W'(TAPS)) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rd_addr   <= ring_pos_inc;
      tap_cnt   <= '0;
      shape_idx <= '0;
      neg       <= 1'b0;
      acc       <= '0;
    end else begin
      if (state == MAC_RUN) begin
        rd_addr <= (rd_addr == ADDR_W'(TAPS - 1)) ? '0 : rd_addr + 1'b1;
        tap_cnt <= tap_cnt + 1'b1;
        if (shape_idx == SHAPE_IDX_W'(SHAPE_LEN - 1)) begin
          shape_idx <= '0;
          neg       <= !neg;
        end else begin
          shape_idx <= shape_idx + 1'b1;
        end
      end
      if (v2) begin
        acc <= acc + ACC_W'(prod);
      end
    end
    zero1 <= (FILL_W'(rd_addr) >= fill);
    coef1 <= neg ? -SHAPE_Q14[shape_idx] : SHAPE_Q14[shape_idx];
    prod  <= zero1 ? '0 : PROD_W'(rdata * coef1);
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == MAC_IDLE)
    else $error("start while correlation in progress");

  a_done_drained: assert property (@(posedge clk) disable iff (rst)
    done |-> !v1 && !v2 && tap_cnt == ADDR_W'(TAPS))
    else $error("correlation finished with taps still in flight");

  a_run_tap_range: assert property (@(posedge clk) disable iff (rst)
    state == MAC_RUN |-> tap_cnt <= ADDR_W'(TAPS - 1))
    else $error("tap counter ran past the delay line");

endmodule

>>> rtl/csy_timing.sv
// Peak detection, symbol phase tracking and decision scheduling.
// Consumes correlations from csy_mac; uses csy_pkg.
module csy_timing
  import csy_pkg::*;
#(
  parameter int SAMPLES_PER_SYMBOL = SPS_DEF,
  parameter int CORR_W             = 28
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic                     corr_valid,
  input  logic signed [CORR_W-1:0] corr,
  input  logic [THRESH_W-1:0]      threshold,
  output logic                     due
);

  localparam int PERIOD = 10 * SAMPLES_PER_SYMBOL;
  localparam int HALF   = 5 * SAMPLES_PER_SYMBOL;
  localparam int PH_W   = $clog2(PERIOD + 10);
  localparam int CMP_W  = (CORR_W > THRESH_W + 1) ? CORR_W : THRESH_W + 1;

  logic signed [CORR_W-1:0] corr_prev;
  logic signed [CORR_W-1:0] corr_mid;
  logic [PH_W-1:0]          phase;
  logic [PH_W-1:0]          phase_nudge;
  logic [PH_W-1:0]          phase_wrap;
  logic [PH_W-1:0]          phase_adv;
  logic                     locked;
  logic                     locked_next;
  logic                     peak;
  logic                     boundary;
  logic [1:0]               pending;
  logic signed [CMP_W-1:0]  mid_ext;
  logic signed [CMP_W-1:0]  thr_ext;

  assign mid_ext = CMP_W'(corr_mid);
  assign thr_ext = $signed(CMP_W'({1'b0, threshold}));

  always_comb begin
    peak = (mid_ext > thr_ext) && (corr_mid > corr_prev) && (corr_mid >= corr);
    locked_next = locked || peak;
    phase_nudge = phase;
    if (peak && phase != '0) begin
      phase_nudge = (phase >= PH_W'(HALF)) ? phase + 1'b1 : phase - 1'b1;
    end
    phase_wrap = (phase_nudge >= PH_W'(PERIOD)) ? phase_nudge - PH_W'(PERIOD) : phase_nudge;
    boundary   = (phase_wrap < PH_W'(5)) || (phase_wrap >= PH_W'(PERIOD - 5));
    phase_adv  = phase_wrap + PH_W'(10);
    if (phase_adv >= PH_W'(PERIOD)) begin
      phase_adv = phase_adv - PH_W'(PERIOD);
    end
  end

  assign due = pending[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      corr_prev <= '0;
      corr_mid  <= '0;
      phase     <= '0;
      locked    <= 1'b0;
      pending   <= '0;
    end else begin
      if (accept) begin
        pending <= {1'b0, pending[1]};
      end
      if (corr_valid) begin
        corr_prev <= corr_mid;
        corr_mid  <= corr;
        locked    <= locked_next;
        phase     <= locked_next ? phase_adv : phase_wrap;
        if (locked_next && boundary) begin
          pending[1] <= 1'b1;
        end
      end
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase < PH_W'(PERIOD))
    else $error("symbol phase out of range");

  a_lock_sticky: assert property (@(posedge clk) disable iff (rst)
    locked |=> locked)
    else $error("lock dropped without reset");

  a_no_due_unlocked: assert property (@(posedge clk) disable iff (rst)
    !locked |-> pending == 2'b00)
    else $error("decision scheduled before lock");

endmodule

>>> rtl/correlator_peak_symbol_sync.sv
// Top level: correlator with peak-driven symbol timing and hard decisions.
// Each item runs one multiply-accumulate per delay line tap through the single
// memory read port, plus pipeline drain; a new sample waits until it finishes.
// A symbol item is registered on the edge that accepts the sample it decides.
// Synchronous active-high reset; delay line reads zero until written via a fill
// count, so no clearing pass follows reset. Threshold resets to 200.
module correlator_peak_symbol_sync
  import csy_pkg::*;
#(
  parameter int TAPS               = TAPS_DEF,
  parameter int SAMPLES_PER_SYMBOL = SPS_DEF,
  parameter int SAMPLE_WIDTH       = SAMPLE_W_DEF
) (
  input  logic         clk,
  input  logic         rst,
  csy_sample_if.sink   samples,
  csy_symbol_if.source symbols,
  csy_cfg_if.sink      cfg
);

  localparam int CORR_W = SAMPLE_WIDTH + 1 + $clog2(TAPS);

  logic [THRESH_W-1:0]      threshold;
  logic                     mac_idle;
  logic                     mac_done;
  logic signed [CORR_W-1:0] corr;
  logic                     due;
  logic                     accept;
  logic                     out_valid;
  logic                     out_symbol;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg.valid) begin
      threshold <= cfg.peak_threshold;
    end
  end

  assign samples.ready = mac_idle && !(due && out_valid && !symbols.ready);
  assign accept        = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && due) begin
      out_valid <= 1'b1;
    end else if (symbols.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && due) begin
      out_symbol <= !samples.sample[SAMPLE_WIDTH-1];
    end
  end

  assign symbols.valid           = out_valid;
  assign symbols.symbol_positive = out_symbol;

  csy_mac #(
    .TAPS         (TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .sample (samples.sample),
    .idle   (mac_idle),
    .done   (mac_done),
    .corr   (corr)
  );

  csy_timing #(
    .SAMPLES_PER_SYMBOL (SAMPLES_PER_SYMBOL),
    .CORR_W             (CORR_W)
  ) u_timing (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .corr_valid (mac_done),
    .corr       (corr),
    .threshold  (threshold),
    .due        (due)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !samples.ready)
    else $error("sample accepted while correlation in progress");

  a_decision_loaded: assert property (@(posedge clk) disable iff (rst)
    accept && due |=> symbols.valid)
    else $error("due decision not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !symbols.ready && due |-> !samples.ready)
    else $error("pending symbol item could be overwritten");

endmodule
